[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, disabled while arst_n is low
`define DCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked on clk, checked during reset as well
`define DCP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[sv/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// dcp_pkg
// Types, register map, character codes and reset values of the drive
// command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcp_pkg;

	localparam int MAX_DIGITS_DEF = 7;

	localparam int SPEED_W   = 8;
	localparam int TIMEOUT_W = 16;
	localparam int DIGIT_W   = 24;
	localparam int SILENCE_W = 17;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [SPEED_W-1:0]   SPD_LO_RST        = 8'd0;
	localparam logic [SPEED_W-1:0]   SPD_HI_RST        = 8'd255;
	localparam logic [SPEED_W-1:0]   DEFAULT_SPEED_RST = 8'd200;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST       = 16'd1000;

	typedef enum logic [1:0] {
		REG_SPD_LO        = 2'd0,
		REG_SPD_HI        = 2'd1,
		REG_DEFAULT_SPEED = 2'd2,
		REG_TIMEOUT       = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		ACT_STOP      = 4'd0,
		ACT_FWD       = 4'd1,
		ACT_REV       = 4'd2,
		ACT_LEFT      = 4'd3,
		ACT_RIGHT     = 4'd4,
		ACT_FWD_LEFT  = 4'd5,
		ACT_FWD_RIGHT = 4'd6,
		ACT_REV_LEFT  = 4'd7,
		ACT_REV_RIGHT = 4'd8
	} action_t;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_Q     = 8'h51;

	typedef struct packed {
		logic [SPEED_W-1:0]   spd_lo;
		logic [SPEED_W-1:0]   spd_hi;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic               action_valid;
		action_t            action;
		logic [SPEED_W-1:0] drive_speed;
		logic               by_failsafe;
		logic               speed_updated;
	} result_t;

endpackage

[sv/dcp_if.sv]
// ----------------------------------------------------------------------------
// dcp_cmd_if / dcp_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcp_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface dcp_res_if;
	logic       valid;
	logic       ready;
	logic       action_valid;
	logic [3:0] action;
	logic [7:0] drive_speed;
	logic       by_failsafe;
	logic       speed_updated;

	modport source (output valid, output action_valid, output action, output drive_speed,
		output by_failsafe, output speed_updated, input ready);
	modport sink (input valid, input action_valid, input action, input drive_speed,
		input by_failsafe, input speed_updated, output ready);
endinterface

[sv/dcp_regs.sv]
// ----------------------------------------------------------------------------
// dcp_regs
// APB configuration registers: speed bounds, default speed, silence timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcp_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dcp_pkg::APB_AW-1:0]  paddr,
	input  logic [dcp_pkg::APB_DW-1:0]  pwdata,
	output logic [dcp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output dcp_pkg::cfg_t               cfg
);

	logic [dcp_pkg::SPEED_W-1:0]   spd_lo_q;
	logic [dcp_pkg::SPEED_W-1:0]   spd_hi_q;
	logic [dcp_pkg::SPEED_W-1:0]   default_speed_q;
	logic [dcp_pkg::TIMEOUT_W-1:0] timeout_q;
	dcp_pkg::reg_idx_t             idx;
	logic                          wr_en;

	assign pready = 1'b1;
	assign idx    = dcp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_lo_q        <= dcp_pkg::SPD_LO_RST;
			spd_hi_q        <= dcp_pkg::SPD_HI_RST;
			default_speed_q <= dcp_pkg::DEFAULT_SPEED_RST;
			timeout_q       <= dcp_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				dcp_pkg::REG_SPD_LO:        spd_lo_q        <= pwdata[7:0];
				dcp_pkg::REG_SPD_HI:        spd_hi_q        <= pwdata[7:0];
				dcp_pkg::REG_DEFAULT_SPEED: default_speed_q <= pwdata[7:0];
				dcp_pkg::REG_TIMEOUT:       timeout_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dcp_pkg::REG_SPD_LO:        prdata = {24'd0, spd_lo_q};
			dcp_pkg::REG_SPD_HI:        prdata = {24'd0, spd_hi_q};
			dcp_pkg::REG_DEFAULT_SPEED: prdata = {24'd0, default_speed_q};
			dcp_pkg::REG_TIMEOUT:       prdata = {16'd0, timeout_q};
			default:                    prdata = '0;
		endcase
	end

	assign cfg.spd_lo        = spd_lo_q;
	assign cfg.spd_hi        = spd_hi_q;
	assign cfg.timeout_ticks = timeout_q;

endmodule

[sv/dcp_core.sv]
// ----------------------------------------------------------------------------
// dcp_core
// Parser state and the single-step update for one byte or tick request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcp_core #(
	parameter int MAX_DIGITS = dcp_pkg::MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              opcode,
	input  logic [7:0]        rx_byte,
	input  dcp_pkg::cfg_t     cfg,
	output dcp_pkg::result_t  res
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);

	logic                            in_cmd_q, in_cmd_d;
	logic [CntW-1:0]                 dcnt_q, dcnt_d;
	logic [dcp_pkg::DIGIT_W-1:0]     dval_q, dval_d;
	logic [dcp_pkg::SPEED_W-1:0]     speed_q, speed_d;
	logic [dcp_pkg::SILENCE_W-1:0]   sil_q, sil_d, sil_inc;
	logic                            fs_done_q, fs_done_d;

	logic [7:0]                      up_byte;
	logic                            hit;
	dcp_pkg::action_t                letter_act;
	logic                            is_digit;
	logic                            line_end;
	logic                            in_range;
	logic [3:0]                      digit;
	logic [dcp_pkg::DIGIT_W-1:0]     dval_acc;

	assign up_byte = (rx_byte >= dcp_pkg::CH_LOW_A && rx_byte <= dcp_pkg::CH_LOW_Z) ?
		rx_byte - dcp_pkg::CASE_OFS : rx_byte;

	always_comb begin
		hit        = 1'b1;
		letter_act = dcp_pkg::ACT_STOP;
		case (up_byte)
			dcp_pkg::CH_F: letter_act = dcp_pkg::ACT_FWD;
			dcp_pkg::CH_B: letter_act = dcp_pkg::ACT_REV;
			dcp_pkg::CH_L: letter_act = dcp_pkg::ACT_LEFT;
			dcp_pkg::CH_R: letter_act = dcp_pkg::ACT_RIGHT;
			dcp_pkg::CH_G: letter_act = dcp_pkg::ACT_FWD_LEFT;
			dcp_pkg::CH_I: letter_act = dcp_pkg::ACT_FWD_RIGHT;
			dcp_pkg::CH_H: letter_act = dcp_pkg::ACT_REV_LEFT;
			dcp_pkg::CH_J: letter_act = dcp_pkg::ACT_REV_RIGHT;
			dcp_pkg::CH_S: letter_act = dcp_pkg::ACT_STOP;
			dcp_pkg::CH_Q: letter_act = dcp_pkg::ACT_STOP;
			default:       hit        = 1'b0;
		endcase
	end

	assign is_digit = rx_byte inside {[dcp_pkg::CH_ZERO:dcp_pkg::CH_NINE]};
	assign line_end = (rx_byte == dcp_pkg::CH_LF) || (rx_byte == dcp_pkg::CH_CR);
	assign digit    = 4'(rx_byte - dcp_pkg::CH_ZERO);
	// value * 10 + digit as two shifts and adds
	assign dval_acc = {dval_q[dcp_pkg::DIGIT_W-4:0], 3'b000}
		+ {dval_q[dcp_pkg::DIGIT_W-2:0], 1'b0}
		+ dcp_pkg::DIGIT_W'(digit);
	assign in_range = (dval_q >= dcp_pkg::DIGIT_W'(cfg.spd_lo))
		&& (dval_q <= dcp_pkg::DIGIT_W'(cfg.spd_hi));
	assign sil_inc  = (sil_q == '1) ? sil_q : sil_q + 1'b1;

	always_comb begin
		in_cmd_d  = in_cmd_q;
		dcnt_d    = dcnt_q;
		dval_d    = dval_q;
		speed_d   = speed_q;
		sil_d     = sil_q;
		fs_done_d = fs_done_q;
		res.action_valid  = 1'b0;
		res.action        = dcp_pkg::ACT_STOP;
		res.by_failsafe   = 1'b0;
		res.speed_updated = 1'b0;

		if (opcode == dcp_pkg::OP_TICK) begin
			sil_d = sil_inc;
			if (sil_inc > dcp_pkg::SILENCE_W'(cfg.timeout_ticks) && !fs_done_q) begin
				fs_done_d        = 1'b1;
				res.action_valid = 1'b1;
				res.by_failsafe  = 1'b1;
			end
		end else begin
			sil_d     = '0;
			fs_done_d = 1'b0;
			if (rx_byte == dcp_pkg::CH_HASH) begin
				// restart the speed command
				in_cmd_d = 1'b1;
				dcnt_d   = '0;
				dval_d   = '0;
			end else if (in_cmd_q) begin
				if (line_end) begin
					in_cmd_d = 1'b0;
					if (dcnt_q != '0 && in_range) begin
						speed_d           = dval_q[dcp_pkg::SPEED_W-1:0];
						res.speed_updated = 1'b1;
					end
				end else if (is_digit && dcnt_q < CntW'(MAX_DIGITS)) begin
					dval_d = dval_acc;
					dcnt_d = dcnt_q + 1'b1;
				end
			end else if (hit) begin
				res.action_valid = 1'b1;
				res.action       = letter_act;
			end
		end
		res.drive_speed = speed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cmd_q  <= 1'b0;
			dcnt_q    <= '0;
			dval_q    <= '0;
			speed_q   <= dcp_pkg::DEFAULT_SPEED_RST;
			sil_q     <= '0;
			fs_done_q <= 1'b0;
		end else if (accept) begin
			in_cmd_q  <= in_cmd_d;
			dcnt_q    <= dcnt_d;
			dval_q    <= dval_d;
			speed_q   <= speed_d;
			sil_q     <= sil_d;
			fs_done_q <= fs_done_d;
		end
	end

endmodule

[sv/drive_command_parser.sv]
// ----------------------------------------------------------------------------
// drive_command_parser
// Parses command bytes and millisecond ticks into motor actions, speed
// updates and a one-shot failsafe stop on silence.
// ----------------------------------------------------------------------------
// An accepted request's result is on the output in the next cycle.
// Throughput: 1 request per cycle when not stalled; the parser state advances
// in one step per request and the result sits in a single output register.
// cmd.ready stays high while the output register is empty or being drained.
// Reset (arst_n low): parser state cleared, current speed set to 200,
// registers to their defaults, output register emptied.
`timescale 1ns / 1ps

module drive_command_parser #(
	parameter int MAX_DIGITS = dcp_pkg::MAX_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dcp_cmd_if.sink                    cmd,
	dcp_res_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dcp_pkg::APB_AW-1:0] paddr,
	input  logic [dcp_pkg::APB_DW-1:0] pwdata,
	output logic [dcp_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	dcp_pkg::cfg_t    cfg;
	dcp_pkg::result_t res_d;
	dcp_pkg::result_t res_s1;
	logic             res_valid_q;
	logic             accept;

	dcp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign cmd.ready = !res_valid_q || result.ready;
	assign accept    = cmd.valid && cmd.ready;

	dcp_core #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.opcode  (cmd.opcode),
		.rx_byte (cmd.rx_byte),
		.cfg     (cfg),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			res_valid_q <= accept;
		end
	end

	// payload loads only with a new request
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.action_valid  = res_s1.action_valid;
	assign result.action        = res_s1.action;
	assign result.drive_speed   = res_s1.drive_speed;
	assign result.by_failsafe   = res_s1.by_failsafe;
	assign result.speed_updated = res_s1.speed_updated;

endmodule

[sv/dcp_checker.sv]
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks of the drive command parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       action_valid,
	input logic [3:0] action,
	input logic [7:0] drive_speed,
	input logic       by_failsafe,
	input logic       speed_updated
);

	`DCP_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(action) && $stable(drive_speed), "stalled result changed")
	`DCP_ASSERT(a_req_to_res, cmd_valid && cmd_ready |=> res_valid, "accepted request gave no result")
	`DCP_ASSERT_ALWAYS(a_ready, !cmd_ready |-> res_valid && !res_ready, "request stalled with free output")
	`DCP_ASSERT(a_failsafe_stop, res_valid && by_failsafe |-> action_valid && action == dcp_pkg::ACT_STOP && !speed_updated, "failsafe result is not a plain stop")
	`DCP_ASSERT(a_no_action, res_valid && !action_valid |-> action == dcp_pkg::ACT_STOP && !by_failsafe, "idle result carries an action")

endmodule

bind drive_command_parser dcp_checker u_dcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.action_valid  (result.action_valid),
	.action        (result.action),
	.drive_speed   (result.drive_speed),
	.by_failsafe   (result.by_failsafe),
	.speed_updated (result.speed_updated)
);
